### design/mtp_pkg.sv
// Shared types, phase codes and constants for the MIDI track event parser.
package mtp_pkg;

   // parser phases
   localparam logic [3:0] PH_HEADER   = 4'd0;
   localparam logic [3:0] PH_CSKIP    = 4'd1;
   localparam logic [3:0] PH_DELTA    = 4'd2;
   localparam logic [3:0] PH_STATUS   = 4'd3;
   localparam logic [3:0] PH_METATYPE = 4'd4;
   localparam logic [3:0] PH_LEN      = 4'd5;
   localparam logic [3:0] PH_TSKIP    = 4'd6;
   localparam logic [3:0] PH_DATA     = 4'd7;
   localparam logic [3:0] PH_SWALLOW  = 4'd8;

   // event kinds
   localparam logic [2:0] EV_NOTE_OFF  = 3'd0;
   localparam logic [2:0] EV_NOTE_ON   = 3'd1;
   localparam logic [2:0] EV_OTHER     = 3'd2;
   localparam logic [2:0] EV_END_TRACK = 3'd3;
   localparam logic [2:0] EV_TRUNCATED = 3'd4;
   localparam logic [2:0] EV_OVERRUN   = 3'd5;

   localparam logic [7:0] META_STATUS   = 8'hFF;
   localparam logic [7:0] META_END      = 8'h2F;
   localparam logic [3:0] STATUS_NOTEOFF = 4'h8;
   localparam logic [3:0] STATUS_NOTEON  = 4'h9;
   localparam logic [3:0] STATUS_SYSTEM  = 4'hF;
   localparam logic [2:0] STATUS_ONEDATA = 3'b110;   // C0..DF carry one data byte

   typedef struct packed {
      logic        valid;
      logic [2:0]  event_kind;
      logic [3:0]  channel;
      logic [27:0] delta_ticks;
      logic [7:0]  status_byte;
      logic [7:0]  first_data;
      logic [7:0]  second_data;
   } result_type;

   // "MTrk" chunk tag
   function automatic logic [7:0] track_tag(input logic [1:0] idx);
      logic [7:0] t;
      case (idx)
         2'd0:    t = 8'h4D;
         2'd1:    t = 8'h54;
         2'd2:    t = 8'h72;
         default: t = 8'h6B;
      endcase
      return t;
   endfunction

endpackage

### design/mtp_parser.sv
// Parser state registers and the per-word next-state and result logic.
module mtp_parser #(
   parameter int VARLEN_MAX_BYTES = 4
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step,
   input  logic [7:0]            stream_byte,
   input  logic                  last_byte,
   output mtp_pkg::result_type   res
);

   logic [3:0]  phase_ff, phase_in;
   logic [2:0]  hidx_ff, hidx_in;
   logic        is_track_ff, is_track_in;
   logic [31:0] chunk_len_ff, chunk_len_in;
   logic [27:0] delta_ff, delta_in;
   logic [2:0]  vcnt_ff, vcnt_in;
   logic [31:0] skip_ff, skip_in;
   logic [7:0]  held_status_ff, held_status_in;
   logic [7:0]  held_data_ff, held_data_in;
   logic [1:0]  data_rem_ff, data_rem_in;
   logic        stopped_ff, stopped_in;

   logic        is_track_base;
   logic [31:0] chunk_len_base;
   logic [2:0]  vcnt_inc;
   logic        overrun;
   logic [31:0] skip_dec;
   logic [27:0] skip_shift;
   logic        two_data;
   logic [3:0]  status_hi;

   always_comb begin
      phase_in       = phase_ff;
      hidx_in        = hidx_ff;
      is_track_in    = is_track_ff;
      chunk_len_in   = chunk_len_ff;
      delta_in       = delta_ff;
      vcnt_in        = vcnt_ff;
      skip_in        = skip_ff;
      held_status_in = held_status_ff;
      held_data_in   = held_data_ff;
      data_rem_in    = data_rem_ff;
      stopped_in     = stopped_ff;
      res            = '0;

      is_track_base  = (hidx_ff == 3'd0) ? 1'b1 : is_track_ff;
      chunk_len_base = (hidx_ff == 3'd0) ? 32'd0 : chunk_len_ff;
      vcnt_inc       = vcnt_ff + 3'd1;
      overrun        = stream_byte[7] && (32'(vcnt_inc) >= 32'(VARLEN_MAX_BYTES));
      skip_dec       = skip_ff - 32'd1;
      skip_shift     = {skip_ff[20:0], stream_byte[6:0]};
      two_data       = held_status_ff[7:5] != mtp_pkg::STATUS_ONEDATA;
      status_hi      = held_status_ff[7:4];

      if (!stopped_ff) begin
         unique case (phase_ff)
            mtp_pkg::PH_HEADER: begin
               is_track_in  = is_track_base;
               chunk_len_in = chunk_len_base;
               if (!hidx_ff[2]) begin
                  if (stream_byte != mtp_pkg::track_tag(hidx_ff[1:0]))
                     is_track_in = 1'b0;
               end else begin
                  chunk_len_in = {chunk_len_base[23:0], stream_byte};
               end
               hidx_in = hidx_ff + 3'd1;   // wraps to zero after the eighth byte
               if (hidx_ff == 3'd7) begin
                  if (is_track_in) begin
                     phase_in = mtp_pkg::PH_DELTA;
                     delta_in = '0;
                     vcnt_in  = '0;
                  end else if (chunk_len_in != 32'd0) begin
                     skip_in  = chunk_len_in;
                     phase_in = mtp_pkg::PH_CSKIP;
                  end
               end
            end
            mtp_pkg::PH_CSKIP: begin
               skip_in = skip_dec;
               if (skip_dec == 32'd0) phase_in = mtp_pkg::PH_HEADER;
            end
            mtp_pkg::PH_DELTA: begin
               delta_in = {delta_ff[20:0], stream_byte[6:0]};
               vcnt_in  = vcnt_inc;
               if (overrun) begin
                  res.valid      = 1'b1;
                  res.event_kind = mtp_pkg::EV_OVERRUN;
                  stopped_in     = 1'b1;
               end else if (!stream_byte[7]) begin
                  vcnt_in  = '0;
                  phase_in = mtp_pkg::PH_STATUS;
               end
            end
            mtp_pkg::PH_STATUS: begin
               if (!stream_byte[7]) begin
                  // stray data byte: drop it and read a new delta time
                  phase_in = mtp_pkg::PH_DELTA;
                  delta_in = '0;
                  vcnt_in  = '0;
               end else if (stream_byte == mtp_pkg::META_STATUS) begin
                  phase_in = mtp_pkg::PH_METATYPE;
               end else if (stream_byte[7:4] == mtp_pkg::STATUS_SYSTEM) begin
                  skip_in  = '0;
                  vcnt_in  = '0;
                  phase_in = mtp_pkg::PH_LEN;
               end else begin
                  held_status_in = stream_byte;
                  held_data_in   = '0;
                  data_rem_in    = (stream_byte[7:5] == mtp_pkg::STATUS_ONEDATA) ?
                                   2'd1 : 2'd2;
                  phase_in       = mtp_pkg::PH_DATA;
               end
            end
            mtp_pkg::PH_METATYPE: begin
               if (stream_byte == mtp_pkg::META_END) begin
                  res.valid       = 1'b1;
                  res.event_kind  = mtp_pkg::EV_END_TRACK;
                  res.delta_ticks = delta_ff;
                  phase_in        = mtp_pkg::PH_SWALLOW;
               end else begin
                  skip_in  = '0;
                  vcnt_in  = '0;
                  phase_in = mtp_pkg::PH_LEN;
               end
            end
            mtp_pkg::PH_LEN: begin
               skip_in = 32'(skip_shift);
               vcnt_in = vcnt_inc;
               if (overrun) begin
                  res.valid      = 1'b1;
                  res.event_kind = mtp_pkg::EV_OVERRUN;
                  stopped_in     = 1'b1;
               end else if (!stream_byte[7]) begin
                  vcnt_in = '0;
                  if (skip_shift == 28'd0) begin
                     phase_in = mtp_pkg::PH_DELTA;
                     delta_in = '0;
                  end else begin
                     phase_in = mtp_pkg::PH_TSKIP;
                  end
               end
            end
            mtp_pkg::PH_TSKIP: begin
               skip_in = skip_dec;
               if (skip_dec == 32'd0) begin
                  phase_in = mtp_pkg::PH_DELTA;
                  delta_in = '0;
                  vcnt_in  = '0;
               end
            end
            mtp_pkg::PH_DATA: begin
               if (data_rem_ff == 2'd2) begin
                  held_data_in = stream_byte;
                  data_rem_in  = 2'd1;
               end else begin
                  res.valid       = 1'b1;
                  res.event_kind  = (status_hi == mtp_pkg::STATUS_NOTEOFF) ?
                                    mtp_pkg::EV_NOTE_OFF :
                                    (status_hi == mtp_pkg::STATUS_NOTEON) ?
                                    mtp_pkg::EV_NOTE_ON : mtp_pkg::EV_OTHER;
                  res.channel     = held_status_ff[3:0];
                  res.delta_ticks = delta_ff;
                  res.status_byte = held_status_ff;
                  res.first_data  = two_data ? held_data_ff : stream_byte;
                  res.second_data = two_data ? stream_byte : 8'd0;
                  data_rem_in     = '0;
                  phase_in        = mtp_pkg::PH_DELTA;
                  delta_in        = '0;
                  vcnt_in         = '0;
               end
            end
            default: begin
               // end-of-track swallow byte and unused codes
               phase_in = mtp_pkg::PH_HEADER;
               hidx_in  = '0;
            end
         endcase
      end

      if (last_byte) begin
         if (!res.valid && !stopped_in &&
             !(phase_in == mtp_pkg::PH_HEADER && hidx_in == 3'd0)) begin
            res            = '0;
            res.valid      = 1'b1;
            res.event_kind = mtp_pkg::EV_TRUNCATED;
         end
         phase_in       = mtp_pkg::PH_HEADER;
         hidx_in        = '0;
         is_track_in    = 1'b1;
         chunk_len_in   = '0;
         delta_in       = '0;
         vcnt_in        = '0;
         skip_in        = '0;
         held_status_in = '0;
         held_data_in   = '0;
         data_rem_in    = '0;
         stopped_in     = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= mtp_pkg::PH_HEADER;
         hidx_ff        <= '0;
         is_track_ff    <= 1'b1;
         chunk_len_ff   <= '0;
         delta_ff       <= '0;
         vcnt_ff        <= '0;
         skip_ff        <= '0;
         held_status_ff <= '0;
         held_data_ff   <= '0;
         data_rem_ff    <= '0;
         stopped_ff     <= 1'b0;
      end else if (step) begin
         phase_ff       <= phase_in;
         hidx_ff        <= hidx_in;
         is_track_ff    <= is_track_in;
         chunk_len_ff   <= chunk_len_in;
         delta_ff       <= delta_in;
         vcnt_ff        <= vcnt_in;
         skip_ff        <= skip_in;
         held_status_ff <= held_status_in;
         held_data_ff   <= held_data_in;
         data_rem_ff    <= data_rem_in;
         stopped_ff     <= stopped_in;
      end
   end

endmodule

### design/midi_track_event_parser_core.sv
// Top level: input word register, track parser and result register.
// Parses Standard MIDI File chunk bytes, one byte per req word, and returns channel
// messages, end-of-track, truncation and varlen-overrun events as rsp words. The block
// sustains one byte per cycle while rsp_ready keeps the result register draining; a byte's
// event waits in the input register and passes through the parser into the result register.
// While a result waits on rsp_ready, one more byte is taken into the input register;
// after that req_ready drops until the result is taken. A byte with req_last_byte set
// ends the buffer: a partial chunk or event reports truncation and the parser restarts.
module midi_track_event_parser_core #(
   parameter int VARLEN_MAX_BYTES = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_stream_byte,
   input  logic        req_last_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_event_kind,
   output logic [3:0]  rsp_channel,
   output logic [27:0] rsp_delta_ticks,
   output logic [7:0]  rsp_status_byte,
   output logic [7:0]  rsp_first_data,
   output logic [7:0]  rsp_second_data
);

   logic                 in_v_ff, in_v_in;
   logic [7:0]           in_byte_ff;
   logic                 in_last_ff;
   logic                 out_v_ff, out_v_in;
   mtp_pkg::result_type  out_ff;
   mtp_pkg::result_type  res;
   logic                 fire;

   assign fire      = in_v_ff && (!out_v_ff || rsp_ready);
   assign req_ready = !in_v_ff || fire;

   mtp_parser #(
      .VARLEN_MAX_BYTES(VARLEN_MAX_BYTES)
   ) u_parser (
      .clock       (clock),
      .reset       (reset),
      .step        (fire),
      .stream_byte (in_byte_ff),
      .last_byte   (in_last_ff),
      .res         (res)
   );

   always_comb begin
      in_v_in = in_v_ff;
      if (req_valid && req_ready) in_v_in = 1'b1;
      else if (fire)              in_v_in = 1'b0;

      out_v_in = out_v_ff;
      if (fire)           out_v_in = res.valid;
      else if (rsp_ready) out_v_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_v_ff  <= 1'b0;
         out_v_ff <= 1'b0;
      end else begin
         in_v_ff  <= in_v_in;
         out_v_ff <= out_v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff <= req_stream_byte;
         in_last_ff <= req_last_byte;
      end
      if (fire) out_ff <= res;
   end

   assign rsp_valid       = out_v_ff;
   assign rsp_event_kind  = out_ff.event_kind;
   assign rsp_channel     = out_ff.channel;
   assign rsp_delta_ticks = out_ff.delta_ticks;
   assign rsp_status_byte = out_ff.status_byte;
   assign rsp_first_data  = out_ff.first_data;
   assign rsp_second_data = out_ff.second_data;

endmodule

### tb/sv/midi_track_event_checker.sv
// Event predictor and scoreboard for the MIDI track event parser.
module midi_track_event_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [7:0]  req_stream_byte,
   input  logic        req_last_byte,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [2:0]  rsp_event_kind,
   input  logic [3:0]  rsp_channel,
   input  logic [27:0] rsp_delta_ticks,
   input  logic [7:0]  rsp_status_byte,
   input  logic [7:0]  rsp_first_data,
   input  logic [7:0]  rsp_second_data,
   output int          mismatch_count,
   output int          events_pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int          VARLEN_MAX = 4;
   localparam logic [31:0] TAG_MTRK   = "MTrk";

   typedef struct packed {
      logic [2:0]  kind;
      logic [3:0]  chan;
      logic [27:0] delta;
      logic [7:0]  status;
      logic [7:0]  d1;
      logic [7:0]  d2;
   } track_event_type;

   // parser state mirror
   logic [3:0]  ph;
   int unsigned hdr_idx;
   bit          is_trk;
   logic [31:0] chunk_len;
   logic [27:0] delta_acc;
   logic [2:0]  vlen_n;
   logic [31:0] skip_n;
   logic [7:0]  st_held;
   logic [7:0]  d_held;
   logic [1:0]  d_left;
   bit          halted;

   track_event_type events_due[$];
   track_event_type predicted;
   track_event_type observed;
   bit              produced;
   int              errors = 0;

   function automatic void parser_clear();
      ph        = mtp_pkg::PH_HEADER;
      hdr_idx   = 0;
      is_trk    = 1'b1;
      chunk_len = '0;
      delta_acc = '0;
      vlen_n    = '0;
      skip_n    = '0;
      st_held   = '0;
      d_held    = '0;
      d_left    = '0;
      halted    = 1'b0;
   endfunction

   function automatic void begin_delta();
      ph        = mtp_pkg::PH_DELTA;
      delta_acc = '0;
      vlen_n    = '0;
   endfunction

   // counts one varlen byte; true when the byte limit is hit with continuation set
   function automatic bit varlen_overrun(input logic [7:0] b);
      vlen_n = vlen_n + 3'd1;
      return b[7] && (int'(vlen_n) >= VARLEN_MAX);
   endfunction

   function automatic bit parse_byte(input logic [7:0] b, input logic last,
                                     output track_event_type ev);
      bit         hit;
      logic [3:0] hi;
      hit = 1'b0;
      ev  = '0;
      if (!halted) begin
         case (ph)
            mtp_pkg::PH_HEADER: begin
               if (hdr_idx == 0) begin
                  is_trk    = 1'b1;
                  chunk_len = '0;
               end
               if (hdr_idx < 4) begin
                  if (b != TAG_MTRK[31 - 8 * hdr_idx -: 8]) is_trk = 1'b0;
               end else begin
                  chunk_len = {chunk_len[23:0], b};
               end
               hdr_idx++;
               if (hdr_idx >= 8) begin
                  hdr_idx = 0;
                  if (is_trk) begin
                     begin_delta();
                  end else if (chunk_len != 0) begin
                     skip_n = chunk_len;
                     ph     = mtp_pkg::PH_CSKIP;
                  end
               end
            end
            mtp_pkg::PH_CSKIP: begin
               skip_n = skip_n - 1;
               if (skip_n == 0) ph = mtp_pkg::PH_HEADER;
            end
            mtp_pkg::PH_DELTA: begin
               delta_acc = {delta_acc[20:0], b[6:0]};
               if (varlen_overrun(b)) begin
                  ev.kind = mtp_pkg::EV_OVERRUN;
                  hit     = 1'b1;
                  halted  = 1'b1;
               end else if (!b[7]) begin
                  vlen_n = '0;
                  ph     = mtp_pkg::PH_STATUS;
               end
            end
            mtp_pkg::PH_STATUS: begin
               if (!b[7]) begin
                  begin_delta();   // stray data byte
               end else if (b == mtp_pkg::META_STATUS) begin
                  ph = mtp_pkg::PH_METATYPE;
               end else if (b[7:4] == mtp_pkg::STATUS_SYSTEM) begin
                  skip_n = '0;
                  vlen_n = '0;
                  ph     = mtp_pkg::PH_LEN;
               end else begin
                  st_held = b;
                  d_held  = '0;
                  d_left  = (b[7:5] == mtp_pkg::STATUS_ONEDATA) ? 2'd1 : 2'd2;
                  ph      = mtp_pkg::PH_DATA;
               end
            end
            mtp_pkg::PH_METATYPE: begin
               if (b == mtp_pkg::META_END) begin
                  ev.kind  = mtp_pkg::EV_END_TRACK;
                  ev.delta = delta_acc;
                  hit      = 1'b1;
                  ph       = mtp_pkg::PH_SWALLOW;
               end else begin
                  skip_n = '0;
                  vlen_n = '0;
                  ph     = mtp_pkg::PH_LEN;
               end
            end
            mtp_pkg::PH_LEN: begin
               skip_n = {4'd0, skip_n[20:0], b[6:0]};
               if (varlen_overrun(b)) begin
                  ev.kind = mtp_pkg::EV_OVERRUN;
                  hit     = 1'b1;
                  halted  = 1'b1;
               end else if (!b[7]) begin
                  vlen_n = '0;
                  if (skip_n == 0) begin_delta();
                  else ph = mtp_pkg::PH_TSKIP;
               end
            end
            mtp_pkg::PH_TSKIP: begin
               skip_n = skip_n - 1;
               if (skip_n == 0) begin_delta();
            end
            mtp_pkg::PH_DATA: begin
               if (d_left == 2'd2) begin
                  d_held = b;
                  d_left = 2'd1;
               end else begin
                  hi = st_held[7:4];
                  ev.kind = (hi == mtp_pkg::STATUS_NOTEOFF) ? mtp_pkg::EV_NOTE_OFF :
                            (hi == mtp_pkg::STATUS_NOTEON)  ? mtp_pkg::EV_NOTE_ON  :
                            mtp_pkg::EV_OTHER;
                  ev.chan   = st_held[3:0];
                  ev.delta  = delta_acc;
                  ev.status = st_held;
                  if (st_held[7:5] == mtp_pkg::STATUS_ONEDATA) begin
                     ev.d1 = b;
                  end else begin
                     ev.d1 = d_held;
                     ev.d2 = b;
                  end
                  hit    = 1'b1;
                  d_left = '0;
                  begin_delta();
               end
            end
            default: begin
               ph      = mtp_pkg::PH_HEADER;
               hdr_idx = 0;
            end
         endcase
      end
      if (last) begin
         // an unfinished chunk or event at the end of the buffer is truncation
         if (!hit && !halted && !(ph == mtp_pkg::PH_HEADER && hdr_idx == 0)) begin
            ev      = '0;
            ev.kind = mtp_pkg::EV_TRUNCATED;
            hit     = 1'b1;
         end
         parser_clear();
      end
      return hit;
   endfunction

   function automatic void field_check(input string name, input logic [27:0] want,
                                       input logic [27:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h", $time, name, want, got);
         errors++;
      end
   endfunction

   function automatic void check_event(input track_event_type got);
      track_event_type want;
      if (events_due.size() == 0) begin
         $display("%0t: unexpected event: expected none, actual kind %0d delta 0x%0h",
                  $time, got.kind, got.delta);
         errors++;
      end else begin
         want = events_due.pop_front();
         field_check("event_kind", 28'(want.kind), 28'(got.kind));
         field_check("channel", 28'(want.chan), 28'(got.chan));
         field_check("delta_ticks", want.delta, got.delta);
         field_check("status_byte", 28'(want.status), 28'(got.status));
         field_check("first_data", 28'(want.d1), 28'(got.d1));
         field_check("second_data", 28'(want.d2), 28'(got.d2));
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         parser_clear();
         events_due.delete();
      end else begin
         if (req_valid && req_ready) begin
            produced = parse_byte(req_stream_byte, req_last_byte, predicted);
            if (produced) events_due.push_back(predicted);
         end
         if (rsp_valid && rsp_ready) begin
            observed = '{rsp_event_kind, rsp_channel, rsp_delta_ticks,
                         rsp_status_byte, rsp_first_data, rsp_second_data};
            check_event(observed);
         end
      end
      events_pending <= events_due.size();
      mismatch_count <= errors;
   end

endmodule

### tb/sv/tb_midi_track_event_parser_core.sv
// Testbench top: byte stream stimulus, handshake pacing and verdict for the parser.
module tb_midi_track_event_parser_core;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int          QUIET_LIMIT    = 2000;
   localparam int          RX_HOLD_CYCLES = 120;
   localparam int          FEED_TARGET    = 530;
   localparam logic [31:0] TAG_MTRK       = "MTrk";
   localparam logic [31:0] TAG_MTHD       = "MThd";
   localparam logic [3:0]  STATUS_PROGRAM = 4'hC;
   localparam logic [3:0]  STATUS_PITCH   = 4'hE;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [7:0]  req_stream_byte;
   logic        req_last_byte;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [2:0]  rsp_event_kind;
   logic [3:0]  rsp_channel;
   logic [27:0] rsp_delta_ticks;
   logic [7:0]  rsp_status_byte;
   logic [7:0]  rsp_first_data;
   logic [7:0]  rsp_second_data;
   int          mismatch_count;
   int          events_pending;

   logic [8:0]  feed_q[$];   // {last_byte, stream_byte}
   bit          calm = 1'b0;
   bit          rx_hold_go = 1'b0;
   bit          rx_held = 1'b0;
   int          quiet = 0;

   midi_track_event_parser_core u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_stream_byte (req_stream_byte),
      .req_last_byte   (req_last_byte),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_event_kind  (rsp_event_kind),
      .rsp_channel     (rsp_channel),
      .rsp_delta_ticks (rsp_delta_ticks),
      .rsp_status_byte (rsp_status_byte),
      .rsp_first_data  (rsp_first_data),
      .rsp_second_data (rsp_second_data)
   );

   midi_track_event_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_stream_byte (req_stream_byte),
      .req_last_byte   (req_last_byte),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_event_kind  (rsp_event_kind),
      .rsp_channel     (rsp_channel),
      .rsp_delta_ticks (rsp_delta_ticks),
      .rsp_status_byte (rsp_status_byte),
      .rsp_first_data  (rsp_first_data),
      .rsp_second_data (rsp_second_data),
      .mismatch_count  (mismatch_count),
      .events_pending  (events_pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ---------------- stream building ----------------

   task automatic put_byte(input logic [7:0] b);
      feed_q.push_back({1'b0, b});
   endtask

   task automatic mark_last();
      logic [8:0] w;
      w = feed_q.pop_back();
      w[8] = 1'b1;
      feed_q.push_back(w);
   endtask

   task automatic put_word32(input logic [31:0] v);
      for (int i = 3; i >= 0; i--) put_byte(v[8 * i +: 8]);
   endtask

   task automatic put_varlen(input logic [27:0] v, input int nb);
      for (int i = nb - 1; i >= 0; i--) put_byte({i != 0, v[7 * i +: 7]});
   endtask

   task automatic put_delta();
      int         r;
      int         nb;
      logic [27:0] v;
      r  = $urandom_range(0, 99);
      nb = (r < 60) ? 1 : (r < 80) ? 2 : (r < 92) ? 3 : 4;
      v  = 28'($urandom);
      v  = v & ~(28'hFFFFFFF << (7 * nb));
      put_varlen(v, nb);
   endtask

   task automatic put_track_header();
      put_word32(TAG_MTRK);
      put_word32($urandom);   // track length is not used by the parser
   endtask

   task automatic put_foreign_chunk();
      int len;
      len = $urandom_range(0, 8);
      put_word32($urandom_range(0, 1) ? TAG_MTHD : $urandom);
      put_word32(len);
      repeat (len) put_byte(8'($urandom));
   endtask

   task automatic put_channel_msg();
      logic [7:0] st;
      st = 8'($urandom_range(8'h80, 8'hEF));
      put_byte(st);
      // data bytes are raw; let some carry the top bit
      put_byte(8'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 255) :
                                                $urandom_range(0, 127)));
      if (st[7:5] != mtp_pkg::STATUS_ONEDATA)
         put_byte(8'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 255) :
                                                   $urandom_range(0, 127)));
   endtask

   // meta (non-end) or system event header, without its length
   task automatic put_skip_head(input bit meta);
      logic [7:0] t;
      if (meta) begin
         put_byte(mtp_pkg::META_STATUS);
         t = 8'($urandom);
         if (t == mtp_pkg::META_END) t = 8'h01;
         put_byte(t);
      end else begin
         put_byte(8'($urandom_range({mtp_pkg::STATUS_SYSTEM, 4'h0}, 8'hFE)));
      end
   endtask

   task automatic put_skipped_event(input bit meta);
      int len;
      len = $urandom_range(0, 5);
      put_skip_head(meta);
      put_varlen(28'(len), ($urandom_range(0, 3) == 0) ? 2 : 1);
      repeat (len) put_byte(8'($urandom));
   endtask

   // four continuation bytes, then bytes the stopped parser ignores
   task automatic put_overrun();
      repeat (4) put_byte({1'b1, 7'($urandom)});
      repeat ($urandom_range(0, 4)) put_byte(8'($urandom));
   endtask

   task automatic put_end_track();
      put_delta();
      put_byte(mtp_pkg::META_STATUS);
      put_byte(mtp_pkg::META_END);
      put_byte(($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'h00);
   endtask

   task automatic close_buffer(input int start);
      int keep;
      if ($urandom_range(0, 99) < 20) begin
         keep = $urandom_range(start + 1, feed_q.size());
         while (feed_q.size() > keep) void'(feed_q.pop_back());
      end
      mark_last();
   endtask

   task automatic make_buffer();
      int start;
      int r;
      int n;
      bit done;
      start = feed_q.size();
      done  = 1'b0;
      if ($urandom_range(0, 99) < 8) begin
         repeat ($urandom_range(1, 16)) put_byte(8'($urandom));
      end else begin
         do begin
            if ($urandom_range(0, 3) == 0) put_foreign_chunk();
            put_track_header();
            n = $urandom_range(1, 10);
            for (int i = 0; i < n && !done; i++) begin
               r = $urandom_range(0, 99);
               if (r < 3) begin
                  put_overrun();
                  done = 1'b1;
               end else begin
                  put_delta();
                  if (r < 62) begin
                     put_channel_msg();
                  end else if (r < 72) begin
                     put_skipped_event(1'b1);
                  end else if (r < 80) begin
                     put_skipped_event(1'b0);
                  end else if (r < 88) begin
                     put_byte(8'($urandom_range(0, 127)));   // stray data byte
                  end else if (r < 91) begin
                     put_skip_head(1'($urandom_range(0, 1)));
                     put_overrun();
                     done = 1'b1;
                  end else begin
                     put_channel_msg();
                  end
               end
            end
            if (!done) begin
               if ($urandom_range(0, 99) < 85) put_end_track();
               else done = 1'b1;
            end
         end while (!done && $urandom_range(0, 99) < 30);
      end
      close_buffer(start);
   endtask

   task automatic build_directed();
      put_track_header();
      put_byte(8'h00);
      put_byte({mtp_pkg::STATUS_NOTEON, 4'h0}); put_byte(8'h3C); put_byte(8'h7F);
      put_varlen(28'hFFFFFFF, 4);
      put_byte({mtp_pkg::STATUS_NOTEOFF, 4'hF}); put_byte(8'h00); put_byte(8'hFF);
      put_byte(8'h00);
      put_byte({STATUS_PROGRAM, 4'h5}); put_byte(8'h80);
      put_byte(8'h00);
      put_byte(8'h45);   // stray data byte
      put_varlen(28'd1, 2);
      put_byte({STATUS_PITCH, 4'h3}); put_byte(8'h00); put_byte(8'h40);
      put_byte(8'h00);
      put_byte(mtp_pkg::META_STATUS); put_byte(8'h01); put_byte(8'h00);   // zero-length meta
      put_byte(8'h00);
      put_byte({mtp_pkg::STATUS_SYSTEM, 4'h0}); put_byte(8'h02); put_byte(8'h11);
      put_byte(8'hF7);
      put_byte(8'h00);
      put_byte(mtp_pkg::META_STATUS); put_byte(mtp_pkg::META_END); put_byte(8'h00);
      // zero-length foreign chunk, then a delta time that runs too long
      put_word32(TAG_MTHD); put_word32(32'd0);
      put_track_header();
      put_byte(8'h80); put_byte(8'h81); put_byte(8'hFF); put_byte(8'h80);
      put_byte(8'h55);
      put_byte(8'h00); mark_last();
      // buffer ending inside a chunk header
      put_byte(TAG_MTRK[31:24]); mark_last();
   endtask

   // ---------------- drivers ----------------

   initial begin
      logic [8:0] w;
      reset           <= 1'b1;
      req_valid       <= 1'b0;
      req_stream_byte <= '0;
      req_last_byte   <= 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      build_directed();
      while (feed_q.size() < FEED_TARGET) make_buffer();
      for (int i = 0; i < feed_q.size(); i++) begin
         if (i == 300) rx_hold_go = 1'b1;
         calm = (i >= 400 && i < 480);
         if (!calm) begin
            while ($urandom_range(0, 99) < 28) begin
               req_valid <= 1'b0;
               @(posedge clock);
            end
         end
         w = feed_q[i];
         req_valid       <= 1'b1;
         req_stream_byte <= w[7:0];
         req_last_byte   <= w[8];
         @(posedge clock);
         while (!req_ready) @(posedge clock);
      end
      req_valid <= 1'b0;
      @(posedge clock);
      while (events_pending != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (mismatch_count == 0 && events_pending == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   initial begin
      rsp_ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (rx_hold_go && !rx_held) begin
            // long back-pressure so the block fills and stalls its input
            rx_held = 1'b1;
            rsp_ready <= 1'b0;
            repeat (RX_HOLD_CYCLES) @(posedge clock);
         end else begin
            rsp_ready <= calm || ($urandom_range(0, 99) >= 28);
            @(posedge clock);
         end
      end
   end

   // watchdog: cycles without any word moving on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet <= 0;
      end else if (quiet >= QUIET_LIMIT) begin
         $display("%0t: no handshake for %0d cycles", $time, QUIET_LIMIT);
         $display("Test completed with failures");
         $finish;
      end else begin
         quiet <= quiet + 1;
      end
   end

endmodule

### midi_track_event_parser_core.f
design/mtp_pkg.sv
design/mtp_parser.sv
design/midi_track_event_parser_core.sv
tb/sv/midi_track_event_checker.sv
tb/sv/tb_midi_track_event_parser_core.sv
